// File: sv/dnsfy_pkg.sv
// ----------------------------------------------------------------------------
// dnsfy_pkg: shared types and constants of the joint waypoint densifier
// Widths, defaults and the lane types.
// ----------------------------------------------------------------------------
package dnsfy_pkg;
   localparam int ANGLE_W       = 24;
   localparam int STEP_W        = 24;
   localparam int MAX_JOINTS    = 6;
   localparam int JOINTS_DEF    = 6;
   localparam int MAX_STEPS_DEF = 64;
   localparam int DIFF_W        = ANGLE_W + 1;
   localparam int SQ_W          = 2 * ANGLE_W;
   localparam int SPAN2_W       = SQ_W + 3;
   localparam int CNT_W         = 7;
   localparam int REACH_W       = STEP_W + CNT_W;
   localparam int REACH2_W      = 2 * REACH_W;
   localparam int PROD_W        = DIFF_W + CNT_W;

   typedef logic signed [ANGLE_W-1:0] angle_type;
   typedef logic signed [DIFF_W-1:0]  diff_type;
   typedef logic [CNT_W-1:0]          cnt_type;
endpackage

// File: sv/dnsfy_if.sv
// ----------------------------------------------------------------------------
// dnsfy_if: valid/ready channels of the densifier
// Request carries a waypoint, response carries one path point.
// ----------------------------------------------------------------------------
interface dnsfy_req_if;
   import dnsfy_pkg::*;
   logic      valid;
   logic      ready;
   logic      path_start;
   angle_type in_angle_0, in_angle_1, in_angle_2, in_angle_3, in_angle_4, in_angle_5;
   modport source (output valid, path_start, in_angle_0, in_angle_1, in_angle_2,
                   in_angle_3, in_angle_4, in_angle_5, input ready);
   modport sink   (input valid, path_start, in_angle_0, in_angle_1, in_angle_2,
                   in_angle_3, in_angle_4, in_angle_5, output ready);
endinterface

interface dnsfy_rsp_if;
   import dnsfy_pkg::*;
   logic      valid;
   logic      ready;
   angle_type out_angle_0, out_angle_1, out_angle_2, out_angle_3, out_angle_4, out_angle_5;
   logic      last_of_run;
   logic      steps_clipped;
   modport source (output valid, out_angle_0, out_angle_1, out_angle_2, out_angle_3,
                   out_angle_4, out_angle_5, last_of_run, steps_clipped, input ready);
   modport sink   (input valid, out_angle_0, out_angle_1, out_angle_2, out_angle_3,
                   out_angle_4, out_angle_5, last_of_run, steps_clipped, output ready);
endinterface

// File: sv/densify_joint_waypoints.sv
// ----------------------------------------------------------------------------
// densify_joint_waypoints: joint-space linear densifier
// Splits each waypoint move into up to MAX_STEPS evenly spaced points.
// ----------------------------------------------------------------------------
// Timing: a pass-through waypoint is registered straight into the output
//   register; a densified waypoint goes through ST_SQ, ST_SUM and the step
//   search over k, then each point through ST_MUL, ST_DIV, ST_WAIT on the
//   per-lane dividers and ST_OUT. Throughput: one waypoint at a time; the
//   serial dividers and output stalls hold the input until its run is done.
// Reset: synchronous, clears max_step, previous angles and the path flag.
module densify_joint_waypoints #(
   parameter int JOINTS    = dnsfy_pkg::JOINTS_DEF,
   parameter int MAX_STEPS = dnsfy_pkg::MAX_STEPS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [dnsfy_pkg::STEP_W-1:0]  csr_write_data,
   dnsfy_req_if.sink                     req,
   dnsfy_rsp_if.source                   rsp
);
   import dnsfy_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0, ST_SQ = 3'd1, ST_SUM = 3'd2, ST_SRCH = 3'd3,
                          ST_MUL = 3'd4, ST_DIV = 3'd5, ST_WAIT = 3'd6, ST_OUT = 3'd7;

   logic [2:0]        state_ff, state_in;
   logic [STEP_W-1:0] max_step_ff;
   angle_type         prev_ff [MAX_JOINTS];
   angle_type         tgt_ff  [MAX_JOINTS];
   angle_type         tgt_w   [MAX_JOINTS];
   logic              have_prev_ff;
   logic [SQ_W-1:0]   sq_w    [MAX_JOINTS];
   logic              done_w  [MAX_JOINTS];
   angle_type         pt_w    [MAX_JOINTS];
   logic [SPAN2_W-1:0] span2_ff;
   cnt_type           k_ff, s_ff, steps_ff;
   logic              clip_ff, start_ff;
   logic [REACH_W-1:0] reach_ff;
   logic [REACH2_W-1:0] reach2;
   logic              all_done;
   logic              accept, out_free;
   logic              pass_w, load_point;
   angle_type         o_ang_ff [MAX_JOINTS];
   logic              o_valid_ff, o_last_ff, o_clip_ff;

   assign tgt_w[0] = req.in_angle_0;
   assign tgt_w[1] = (JOINTS > 1) ? req.in_angle_1 : '0;
   assign tgt_w[2] = (JOINTS > 2) ? req.in_angle_2 : '0;
   assign tgt_w[3] = (JOINTS > 3) ? req.in_angle_3 : '0;
   assign tgt_w[4] = (JOINTS > 4) ? req.in_angle_4 : '0;
   assign tgt_w[5] = (JOINTS > 5) ? req.in_angle_5 : '0;

   assign out_free   = ~o_valid_ff | rsp.ready;
   assign req.ready  = (state_ff == ST_IDLE) & out_free;
   assign accept     = req.valid & req.ready;
   assign reach2     = reach_ff * reach_ff;
   // pass the waypoint straight through on a path start, with no previous
   // waypoint, or when densifying is off
   assign pass_w     = req.path_start || !have_prev_ff || (max_step_ff == '0);
   assign load_point = (state_ff == ST_OUT) && out_free;

   // lanes: one per joint, unused joints see zero target and prev
   for (genvar j = 0; j < MAX_JOINTS; j++) begin : g_lane
      dnsfy_lane u_lane (
         .clock(clock), .reset(reset), .load(accept),
         .target(tgt_w[j]), .prev(prev_ff[j]), .diff_sq(sq_w[j]),
         .div_start(start_ff), .s_num(s_ff), .steps(steps_ff),
         .div_done(done_w[j]), .point(pt_w[j]));
   end

   // merge: a point is ready once every lane's divider is done
   always_comb begin
      all_done = 1'b1;
      for (int j = 0; j < MAX_JOINTS; j++) all_done &= done_w[j];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept && !pass_w) state_in = ST_SQ;
         ST_SQ:   state_in = ST_SUM;
         ST_SUM:  state_in = ST_SRCH;
         ST_SRCH: if (reach2 >= REACH2_W'(span2_ff) || k_ff == CNT_W'(MAX_STEPS))
                     state_in = ST_MUL;
         ST_MUL:  state_in = ST_DIV;
         ST_DIV:  state_in = ST_WAIT;
         ST_WAIT: if (all_done) state_in = ST_OUT;
         ST_OUT:  if (out_free) state_in = (s_ff == steps_ff) ? ST_IDLE : ST_MUL;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         max_step_ff  <= '0;
         have_prev_ff <= 1'b0;
         o_valid_ff   <= 1'b0;
         start_ff     <= 1'b0;
         for (int j = 0; j < MAX_JOINTS; j++) prev_ff[j] <= '0;
      end else begin
         state_ff <= state_in;
         // the product for s_ff is registered in ST_MUL, start the dividers after it
         start_ff <= (state_ff == ST_MUL);
         if (csr_write_enable) max_step_ff <= csr_write_data;
         // hold the output word until taken, reload it with each new point
         if ((accept && pass_w) || load_point) o_valid_ff <= 1'b1;
         else if (rsp.ready)                    o_valid_ff <= 1'b0;
         if (accept) begin
            have_prev_ff <= 1'b1;
            for (int j = 0; j < MAX_JOINTS; j++) tgt_ff[j] <= tgt_w[j];
            if (pass_w) begin
               // pass through and take as new previous
               for (int j = 0; j < MAX_JOINTS; j++) begin
                  prev_ff[j]  <= tgt_w[j];
                  o_ang_ff[j] <= tgt_w[j];
               end
               o_last_ff  <= 1'b1;
               o_clip_ff  <= 1'b0;
            end
         end
         case (state_ff)
            ST_SUM: begin
               // sum of lane squares, registered once
               span2_ff <= SPAN2_W'(sq_w[0]) + SPAN2_W'(sq_w[1]) + SPAN2_W'(sq_w[2])
                         + SPAN2_W'(sq_w[3]) + SPAN2_W'(sq_w[4]) + SPAN2_W'(sq_w[5]);
               k_ff     <= CNT_W'(1);
               reach_ff <= REACH_W'(max_step_ff);
               s_ff     <= CNT_W'(1);
            end
            ST_SRCH: begin
               if (reach2 >= REACH2_W'(span2_ff)) begin
                  steps_ff <= k_ff;
                  clip_ff  <= 1'b0;
               end else if (k_ff == CNT_W'(MAX_STEPS)) begin
                  steps_ff <= k_ff;
                  clip_ff  <= 1'b1;
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  reach_ff <= reach_ff + REACH_W'(max_step_ff);
               end
            end
            ST_OUT: if (out_free) begin
               for (int j = 0; j < MAX_JOINTS; j++) o_ang_ff[j] <= pt_w[j];
               o_last_ff  <= (s_ff == steps_ff);
               o_clip_ff  <= clip_ff;
               // advance to the next step, or take the waypoint as new previous
               if (s_ff == steps_ff)
                  for (int j = 0; j < MAX_JOINTS; j++) prev_ff[j] <= tgt_ff[j];
               else
                  s_ff <= s_ff + 1'b1;
            end
            default: ;
         endcase
      end
   end

   assign rsp.valid         = o_valid_ff;
   assign rsp.out_angle_0   = o_ang_ff[0];
   assign rsp.out_angle_1   = o_ang_ff[1];
   assign rsp.out_angle_2   = o_ang_ff[2];
   assign rsp.out_angle_3   = o_ang_ff[3];
   assign rsp.out_angle_4   = o_ang_ff[4];
   assign rsp.out_angle_5   = o_ang_ff[5];
   assign rsp.last_of_run   = o_last_ff;
   assign rsp.steps_clipped = o_clip_ff;
endmodule

// File: sv/dnsfy_divider.sv
// ----------------------------------------------------------------------------
// dnsfy_divider: restoring divider for one joint lane
// Signed truncating quotient of a product by the step count, one bit a cycle.
// ----------------------------------------------------------------------------
module dnsfy_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [dnsfy_pkg::PROD_W-1:0] dividend,
   input  dnsfy_pkg::cnt_type                divisor,
   output logic                              done,
   output logic signed [dnsfy_pkg::PROD_W-1:0] quotient
);
   import dnsfy_pkg::*;
   localparam int BIT_W = $clog2(PROD_W + 1);

   logic [PROD_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [BIT_W-1:0]  bit_ff, bit_in;
   logic              busy_ff, busy_in;
   logic              neg_ff, neg_in;
   logic [CNT_W:0]    trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      neg_in  = neg_ff;
      trial   = {rem_ff, quo_ff[PROD_W-1]};
      if (start) begin
         neg_in  = dividend[PROD_W-1];
         quo_in  = dividend[PROD_W-1] ? PROD_W'(-dividend) : PROD_W'(dividend);
         rem_in  = '0;
         bit_in  = BIT_W'(PROD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so it fits CNT_W bits
         if (trial >= {1'b0, divisor}) begin
            rem_in = CNT_W'(trial - {1'b0, divisor});
            quo_in = {quo_ff[PROD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[CNT_W-1:0];
            quo_in = {quo_ff[PROD_W-2:0], 1'b0};
         end
         bit_in = bit_ff - 1'b1;
         if (bit_ff == BIT_W'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      bit_ff <= bit_in;
      neg_ff <= neg_in;
      if (reset) busy_ff <= 1'b0;
      else       busy_ff <= busy_in;
   end

   assign done     = ~busy_ff;
   assign quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);
endmodule

// File: sv/dnsfy_lane.sv
// ----------------------------------------------------------------------------
// dnsfy_lane: one joint's difference, square and point offset
// Holds diff, produces diff squared and prev + trunc(diff*s/steps).
// ----------------------------------------------------------------------------
module dnsfy_lane (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  dnsfy_pkg::angle_type target,
   input  dnsfy_pkg::angle_type prev,
   output logic [dnsfy_pkg::SQ_W-1:0] diff_sq,
   input  logic                 div_start,
   input  dnsfy_pkg::cnt_type   s_num,
   input  dnsfy_pkg::cnt_type   steps,
   output logic                 div_done,
   output dnsfy_pkg::angle_type point
);
   import dnsfy_pkg::*;

   diff_type           diff_ff, diff_in;
   logic [ANGLE_W-1:0] mag;
   logic [SQ_W-1:0]    sq_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [PROD_W-1:0] quot;

   assign diff_in = load ? diff_type'(target) - diff_type'(prev) : diff_ff;
   // a difference of two 24-bit angles has a magnitude below 2^24
   assign mag     = ANGLE_W'(diff_ff[DIFF_W-1] ? -diff_ff : diff_ff);
   assign prod_in = PROD_W'(diff_ff) * $signed({1'b0, s_num});

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
      sq_ff   <= mag * mag;
      prod_ff <= prod_in;
   end

   assign diff_sq = sq_ff;

   dnsfy_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(prod_ff),
      .divisor(steps), .done(div_done), .quotient(quot));

   assign point = angle_type'(PROD_W'(prev) + quot);
endmodule
